>>> rtl/core/decimal_text_to_fixed_quantizer_macros.svh
// Assertion helpers for the quantizer top level.
`ifndef DECIMAL_TEXT_TO_FIXED_QUANTIZER_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_QUANTIZER_MACROS_SVH

// ante implies cons in the same cycle
`define DTFQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define DTFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dtfq_pkg.sv
`timescale 1ns / 1ps

package dtfq_pkg;

  localparam int unsigned MantW     = 64;
  localparam int unsigned QuotW     = 14;
  localparam int unsigned DivW      = MantW + QuotW;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  localparam logic [4:0]  MaxDigits = 5'd18;
  localparam logic [6:0]  ExpLimit  = 7'd99;
  localparam logic [7:0]  FracMax   = 8'd255;
  localparam logic [QuotW-1:0] Scale = 14'd10000;
  localparam logic signed [14:0] QPos  = 15'sd10000;
  localparam logic signed [14:0] QNeg  = -15'sd10000;
  localparam logic signed [14:0] QZero = 15'sd0;
  localparam logic [4:0]  MaxShift  = 5'd19;

  typedef enum logic [2:0] {
    TK_NEG,
    TK_INT,
    TK_FRAC,
    TK_ENEG,
    TK_EXP,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } token_t;

  function automatic logic [MantW-1:0] pow10(input logic [4:0] k);
    logic [MantW-1:0] p;
    unique case (k)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      5'd19:   p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/core/dtfq_ifs.sv
`timescale 1ns / 1ps

interface dtfq_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface dtfq_tok_if import dtfq_pkg::*; ();
  logic   valid;
  logic   ready;
  token_t tok;
  modport source (output valid, output tok, input ready);
  modport sink   (input valid, input tok, output ready);
endinterface

interface dtfq_res_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] quantized;
  logic              no_digits;
  modport source (output valid, output quantized, output no_digits, input ready);
  modport sink   (input valid, input quantized, input no_digits, output ready);
endinterface

>>> rtl/core/dtfq_front.sv
`timescale 1ns / 1ps

module dtfq_front import dtfq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtfq_char_if.sink    in_i,
  dtfq_tok_if.source   tok_o
);

  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_FRAC,
    PH_ESIGN,
    PH_EDIG
  } phase_e;

  phase_e    phase_q, phase_d;
  logic      emit;
  tok_kind_e kind;
  logic      is_dig, is_dot, is_e, is_minus, is_plus;

  assign is_dig   = (in_i.ch >= 8'd48) && (in_i.ch <= 8'd57);
  assign is_dot   = in_i.ch == 8'd46;
  assign is_e     = (in_i.ch | 8'd32) == 8'd101;
  assign is_minus = in_i.ch == 8'd45;
  assign is_plus  = in_i.ch == 8'd43;

  always_comb begin
    phase_d = phase_q;
    emit    = 1'b1;
    kind    = TK_END;
    unique case (phase_q)
      PH_INT: begin
        if (is_dig) begin
          kind = TK_INT;
        end else if (is_dot) begin
          emit = 1'b0; phase_d = PH_FRAC;
        end else if (is_e) begin
          emit = 1'b0; phase_d = PH_ESIGN;
        end else begin
          phase_d = PH_START;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          kind = TK_FRAC;
        end else if (is_e) begin
          emit = 1'b0; phase_d = PH_ESIGN;
        end else begin
          phase_d = PH_START;
        end
      end
      PH_ESIGN: begin
        if (is_minus) begin
          kind = TK_ENEG; phase_d = PH_EDIG;
        end else if (is_plus) begin
          emit = 1'b0; phase_d = PH_EDIG;
        end else if (is_dig) begin
          kind = TK_EXP; phase_d = PH_EDIG;
        end else begin
          phase_d = PH_START;
        end
      end
      PH_EDIG: begin
        if (is_dig) begin
          kind = TK_EXP;
        end else begin
          phase_d = PH_START;
        end
      end
      default: begin
        if (is_minus) begin
          kind = TK_NEG; phase_d = PH_INT;
        end else if (is_dig) begin
          kind = TK_INT; phase_d = PH_INT;
        end else if (is_dot) begin
          emit = 1'b0; phase_d = PH_FRAC;
        end else if (is_e) begin
          emit = 1'b0; phase_d = PH_ESIGN;
        end else begin
          phase_d = PH_START;
        end
      end
    endcase
  end

  assign in_i.ready      = tok_o.ready;
  assign tok_o.valid     = in_i.valid && tok_o.ready && emit;
  assign tok_o.tok.kind  = kind;
  assign tok_o.tok.digit = in_i.ch[3:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
    end else if (in_i.valid && in_i.ready) begin
      phase_q <= phase_d;
    end
  end

endmodule

>>> rtl/core/dtfq_fifo.sv
`timescale 1ns / 1ps

module dtfq_fifo import dtfq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtfq_tok_if.sink   push_i,
  dtfq_tok_if.source pop_o
);

  token_t          mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_i.ready = cnt_q != CntW'(FifoDepth);
  assign pop_o.valid  = cnt_q != '0;
  assign pop_o.tok    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_i.ready;
  assign do_pop       = pop_o.valid && pop_o.ready;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/core/dtfq_back.sv
`timescale 1ns / 1ps

module dtfq_back import dtfq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtfq_tok_if.sink   tok_i,
  dtfq_res_if.source out_o
);

  typedef enum logic [2:0] {
    S_RUN,
    S_EVAL,
    S_MULCHK,
    S_BIGCHK,
    S_DIV,
    S_ROUND,
    S_DONE
  } state_e;

  state_e           state_q;
  logic [MantW-1:0] mant_q;
  logic [4:0]       kept_q;
  logic [7:0]       frac_q;
  logic [7:0]       drop_q;
  logic             neg_q, eneg_q, seen_q;
  logic [6:0]       eval_q;

  logic [DivW-1:0]  rem_q, dv_q;
  logic [MantW-1:0] pw_q;
  logic [QuotW-1:0] quo_q, mag_q;
  logic [3:0]       bit_q;
  logic             big_q, nd_q;

  logic              out_valid_q;
  logic signed [14:0] quant_q;
  logic              nd_out_q;

  logic [3:0]        dig;
  logic [MantW-1:0]  mant_x10;
  logic [10:0]       exp_x10;
  logic signed [10:0] e_s, x_s;
  logic [10:0]       k_u;
  logic [QuotW-1:0]  scale_up;
  logic [27:0]       prod;
  logic              div_ge;
  logic              do_pop;

  assign dig      = tok_i.tok.digit;
  assign mant_x10 = (mant_q << 3) + (mant_q << 1) + MantW'(dig);
  assign exp_x10  = ({4'b0, eval_q} << 3) + ({4'b0, eval_q} << 1) + 11'(dig);
  assign x_s      = eneg_q ? -$signed({4'b0, eval_q}) : $signed({4'b0, eval_q});
  assign e_s      = $signed({3'b0, drop_q}) - $signed({3'b0, frac_q}) + 11'sd4 + x_s;
  assign k_u      = 11'(-e_s);

  always_comb begin
    unique case (e_s[2:0])
      3'd0:    scale_up = 14'd1;
      3'd1:    scale_up = 14'd10;
      3'd2:    scale_up = 14'd100;
      3'd3:    scale_up = 14'd1000;
      3'd4:    scale_up = 14'd10000;
      default: scale_up = '0;
    endcase
  end

  assign prod     = mant_q[QuotW-1:0] * scale_up;
  assign div_ge   = rem_q >= dv_q;

  assign tok_i.ready = state_q == S_RUN;
  assign do_pop      = tok_i.valid && tok_i.ready;

  assign out_o.valid     = out_valid_q;
  assign out_o.quantized = quant_q;
  assign out_o.no_digits = nd_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      mant_q      <= '0;
      kept_q      <= '0;
      frac_q      <= '0;
      drop_q      <= '0;
      neg_q       <= 1'b0;
      eneg_q      <= 1'b0;
      seen_q      <= 1'b0;
      eval_q      <= '0;
      out_valid_q <= 1'b0;
      big_q       <= 1'b0;
      nd_q        <= 1'b0;
      bit_q       <= '0;
    end else begin
      if (out_o.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_RUN: begin
          if (do_pop) begin
            case (tok_i.tok.kind)
              TK_NEG:  neg_q <= 1'b1;
              TK_ENEG: eneg_q <= 1'b1;
              TK_INT: begin
                seen_q <= 1'b1;
                if (kept_q != '0 || dig != '0) begin
                  if (kept_q < MaxDigits) begin
                    mant_q <= mant_x10;
                    kept_q <= kept_q + 5'd1;
                  end else if (drop_q != 8'hFF) begin
                    drop_q <= drop_q + 8'd1;
                  end
                end
              end
              TK_FRAC: begin
                seen_q <= 1'b1;
                if (frac_q != FracMax) begin
                  if (kept_q == '0 && dig == '0) begin
                    frac_q <= frac_q + 8'd1;
                  end else if (kept_q < MaxDigits) begin
                    mant_q <= mant_x10;
                    kept_q <= kept_q + 5'd1;
                    frac_q <= frac_q + 8'd1;
                  end
                end
              end
              TK_EXP: begin
                eval_q <= (exp_x10 > 11'(ExpLimit)) ? ExpLimit : exp_x10[6:0];
              end
              default: state_q <= S_EVAL;
            endcase
          end
        end
        S_EVAL: begin
          big_q <= 1'b0;
          mag_q <= '0;
          nd_q  <= !seen_q;
          rem_q <= DivW'(mant_q);
          if (!seen_q || kept_q == '0) begin
            state_q <= S_DONE;
          end else if (!e_s[10]) begin
            if (e_s >= 11'sd5 || mant_q >= MantW'(Scale)) begin
              big_q   <= 1'b1;
              state_q <= S_DONE;
            end else begin
              rem_q   <= DivW'(prod);
              state_q <= S_MULCHK;
            end
          end else if (k_u > 11'(MaxShift)) begin
            state_q <= S_DONE;
          end else begin
            pw_q    <= pow10(k_u[4:0]);
            state_q <= S_BIGCHK;
          end
        end
        S_MULCHK: begin
          if (rem_q >= DivW'(Scale)) big_q <= 1'b1;
          else mag_q <= rem_q[QuotW-1:0];
          state_q <= S_DONE;
        end
        S_BIGCHK: begin
          if (rem_q >= {pw_q, QuotW'(0)}) begin
            big_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            dv_q    <= {1'b0, pw_q, (QuotW - 1)'(0)};
            bit_q   <= 4'(QuotW - 1);
            quo_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) rem_q <= rem_q - dv_q;
          quo_q <= {quo_q[QuotW-2:0], div_ge};
          dv_q  <= dv_q >> 1;
          if (bit_q == '0) state_q <= S_ROUND;
          else bit_q <= bit_q - 4'd1;
        end
        S_ROUND: begin
          if (quo_q >= Scale) big_q <= 1'b1;
          else mag_q <= quo_q + QuotW'(rem_q >= DivW'(pw_q >> 1));
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            nd_out_q    <= nd_q;
            if (neg_q) quant_q <= big_q ? QNeg : QZero;
            else       quant_q <= big_q ? QPos : $signed({1'b0, mag_q});
            mant_q  <= '0;
            kept_q  <= '0;
            frac_q  <= '0;
            drop_q  <= '0;
            neg_q   <= 1'b0;
            eneg_q  <= 1'b0;
            seen_q  <= 1'b0;
            eval_q  <= '0;
            state_q <= S_RUN;
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

endmodule

>>> rtl/core/decimal_text_to_fixed_quantizer.sv
`timescale 1ns / 1ps
// Decimal text to fixed-point quantizer. Characters enter on in_i, one per
// cycle while the four-entry token queue has room; a number ends at the first
// character that does not fit it, and that character yields one result on
// out_o: the value times 10000, clamped to -10000..10000 (negative values
// above -1 give 0), rounded half away from zero, with no_digits set when no
// mantissa digit came. The back end retires one queued digit, sign or
// exponent token per cycle while in S_RUN. An ending token goes on to
// S_EVAL, then S_MULCHK for an integer scale-up, or S_BIGCHK, S_DIV (a
// 14-step restoring divider) and S_ROUND when the mantissa must be divided
// by a power of ten, and ends in S_DONE, which waits for out_o; zero and
// saturated values may skip to S_DONE. Characters keep filling the queue meanwhile.
`include "decimal_text_to_fixed_quantizer_macros.svh"

module decimal_text_to_fixed_quantizer import dtfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtfq_char_if.sink   in_i,
  dtfq_res_if.source  out_o
);

  dtfq_tok_if tok_push ();
  dtfq_tok_if tok_pop ();

  dtfq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .tok_o  (tok_push)
  );

  dtfq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (tok_push),
    .pop_o  (tok_pop)
  );

  dtfq_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_pop),
    .out_o  (out_o)
  );

  `DTFQ_ASSERT_NOW(a_q_range, out_o.valid, (out_o.quantized >= QNeg) && (out_o.quantized <= QPos), "quantized out of range")
  `DTFQ_ASSERT_NOW(a_nd_zero, out_o.valid && out_o.no_digits, out_o.quantized == QZero, "empty number with nonzero value")
  `DTFQ_ASSERT_NOW(a_push_src, tok_push.valid, in_i.valid && in_i.ready, "token without accepted request")
  `DTFQ_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid, "result dropped while stalled")

endmodule
